[rtl/cdo_pkg.sv]
package cdo_pkg;

	localparam int unsigned DAY_W   = 5;
	localparam int unsigned MONTH_W = 4;
	localparam int unsigned YEAR_W  = 14;
	localparam int unsigned STEP_W  = 16;
	localparam int unsigned WDAY_W  = 3;
	localparam int unsigned STAT_W  = 2;
	localparam int unsigned CENT_W  = 7;   // century, 0..99
	localparam int unsigned YIC_W   = 7;   // year in century, 0..99
	localparam int unsigned ZSUM_W  = 10;  // Zeller sum, at most 718

	localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STAT_W-1:0] STAT_INVALID = 2'd1;
	localparam logic [STAT_W-1:0] STAT_RANGE   = 2'd2;

	localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
	localparam logic [YEAR_W-1:0]  YEAR_MIN  = 14'd1;
	localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
	localparam logic [CENT_W-1:0]  CENT_LAST = 7'd99;
	localparam logic [YIC_W-1:0]   YIC_LAST  = 7'd99;

	// floor(y / 100) = (y * 5243) >> 19, exact for y below 2**14
	localparam int unsigned DIV100_MUL = 5243;
	localparam int unsigned DIV100_SH  = 19;
	localparam int unsigned DIV100_PW  = YEAR_W + 13;
	// floor(w / 7) = (w * 1171) >> 13, exact for w up to 718
	localparam int unsigned DIV7_MUL = 1171;
	localparam int unsigned DIV7_SH  = 13;
	localparam int unsigned DIV7_PW  = ZSUM_W + 11;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SPLIT,
		ST_REM,
		ST_CHECK,
		ST_STEP,
		ST_WSUM,
		ST_WDIV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [DAY_W-1:0]   day;
		logic [MONTH_W-1:0] month;
		logic [CENT_W-1:0]  cent;
		logic [YIC_W-1:0]   yic;
	} date_t;

	typedef struct packed {
		date_t            next;
		logic             stop;     // boundary reached, step not taken
		logic             leap;
		logic [DAY_W-1:0] mlen;     // length of the current month
	} step_res_t;

	function automatic logic is_leap(input logic [CENT_W-1:0] cent,
		input logic [YIC_W-1:0] yic);
		logic y4;
		y4 = (yic[1:0] == 2'd0);
		if (yic == '0) begin
			return (cent[1:0] == 2'd0);
		end
		return y4;
	endfunction

	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
		input logic leap);
		logic [DAY_W-1:0] r;
		unique case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                   r = 5'd30;
			4'd2:                                      r = leap ? 5'd29 : 5'd28;
			default:                                   r = 5'd0;
		endcase
		return r;
	endfunction

	// floor(26 * (mm + 1) / 10) for Zeller months 3..14
	function automatic logic [5:0] zeller_month(input logic [MONTH_W-1:0] mm);
		logic [5:0] r;
		unique case (mm)
			4'd3:    r = 6'd10;
			4'd4:    r = 6'd13;
			4'd5:    r = 6'd15;
			4'd6:    r = 6'd18;
			4'd7:    r = 6'd20;
			4'd8:    r = 6'd23;
			4'd9:    r = 6'd26;
			4'd10:   r = 6'd28;
			4'd11:   r = 6'd31;
			4'd12:   r = 6'd33;
			4'd13:   r = 6'd36;
			4'd14:   r = 6'd39;
			default: r = 6'd0;
		endcase
		return r;
	endfunction

endpackage

[rtl/cdo_if.sv]
interface cdo_in_if;
	logic                          valid;
	logic                          ready;
	logic [cdo_pkg::DAY_W-1:0]     start_day;
	logic [cdo_pkg::MONTH_W-1:0]   start_month;
	logic [cdo_pkg::YEAR_W-1:0]    start_year;
	logic                          go_back;
	logic [cdo_pkg::STEP_W-1:0]    step_count;

	modport source (output valid, start_day, start_month, start_year, go_back, step_count,
		input ready);
	modport sink (input valid, start_day, start_month, start_year, go_back, step_count,
		output ready);
endinterface

interface cdo_out_if;
	logic                          valid;
	logic                          ready;
	logic [cdo_pkg::DAY_W-1:0]     end_day;
	logic [cdo_pkg::MONTH_W-1:0]   end_month;
	logic [cdo_pkg::YEAR_W-1:0]    end_year;
	logic [cdo_pkg::WDAY_W-1:0]    weekday;
	logic                          leap_year;
	logic [cdo_pkg::DAY_W-1:0]     month_length;
	logic [cdo_pkg::STAT_W-1:0]    status;

	modport source (output valid, end_day, end_month, end_year, weekday, leap_year,
		month_length, status, input ready);
	modport sink (input valid, end_day, end_month, end_year, weekday, leap_year,
		month_length, status, output ready);
endinterface

[rtl/calendar_date_offset_weekday.sv]
// From accept to result valid: setup (year split, date check), one step per day moved
// through the shared day-step unit, days moved being at most min(step_count, MAX_STEPS),
// then weekday arithmetic (Zeller sum, then division by 7) and the output load. An invalid
// start date skips stepping and weekday arithmetic. One item at a time: the next is accepted
// after the result is loaded; a finished result waits in the output register meanwhile.
// Reset (arst_n low): sequencer idle, output register empty.
module calendar_date_offset_weekday #(
	parameter int unsigned MAX_STEPS = 65535
) (
	input  logic             clk,
	input  logic             arst_n,
	cdo_in_if.sink           din,
	cdo_out_if.source        dout
);

	localparam int unsigned NEED_W = $clog2(MAX_STEPS + 1);
	localparam int unsigned LIM_W  = (NEED_W > cdo_pkg::STEP_W) ? NEED_W : cdo_pkg::STEP_W;

	cdo_pkg::state_t state_q, state_d;

	logic [cdo_pkg::DAY_W-1:0]   day_q;
	logic [cdo_pkg::MONTH_W-1:0] month_q;
	logic [cdo_pkg::YEAR_W-1:0]  year_q;
	logic [cdo_pkg::CENT_W-1:0]  cent_q;
	logic [cdo_pkg::YIC_W-1:0]   yic_q;
	logic                        back_q;
	logic [cdo_pkg::STEP_W-1:0]  cnt_q;
	logic [cdo_pkg::STAT_W-1:0]  stat_q;
	logic [cdo_pkg::ZSUM_W-1:0]  wsum_q;
	logic [6:0]                  wquo_q;
	logic                        ov_q;

	logic [cdo_pkg::DAY_W-1:0]   o_day_q;
	logic [cdo_pkg::MONTH_W-1:0] o_month_q;
	logic [cdo_pkg::YEAR_W-1:0]  o_year_q;
	logic [cdo_pkg::WDAY_W-1:0]  o_wday_q;
	logic                        o_leap_q;
	logic [cdo_pkg::DAY_W-1:0]   o_mlen_q;
	logic [cdo_pkg::STAT_W-1:0]  o_stat_q;

	logic                          in_acc;
	logic                          out_free;
	logic [LIM_W-1:0]              cnt_ext;
	logic [LIM_W-1:0]              lim;
	logic [cdo_pkg::STEP_W-1:0]    cnt_cap;
	logic [cdo_pkg::DIV100_PW-1:0] cent_prod;
	logic [cdo_pkg::YEAR_W-1:0]    cent_x100;
	logic [cdo_pkg::DIV7_PW-1:0]   quo_prod;
	logic [cdo_pkg::ZSUM_W-1:0]    wrem;
	logic                          start_bad;
	cdo_pkg::date_t                cur;
	cdo_pkg::step_res_t            sres;

	// Zeller operands
	logic                         early;
	logic [cdo_pkg::CENT_W-1:0]   z_cent;
	logic [cdo_pkg::YIC_W-1:0]    z_yic;
	logic [cdo_pkg::MONTH_W-1:0]  z_mon;
	logic [cdo_pkg::ZSUM_W-1:0]   z_sum;

	assign in_acc   = din.valid && din.ready;
	assign out_free = !ov_q || dout.ready;
	assign din.ready = (state_q == cdo_pkg::ST_IDLE);

	assign cnt_ext = LIM_W'(din.step_count);
	assign lim     = LIM_W'(MAX_STEPS);
	assign cnt_cap = (cnt_ext > lim) ? lim[cdo_pkg::STEP_W-1:0] : din.step_count;

	assign cent_prod = cdo_pkg::DIV100_PW'(year_q) * cdo_pkg::DIV100_PW'(cdo_pkg::DIV100_MUL);
	assign cent_x100 = cdo_pkg::YEAR_W'(cent_q) * 14'd100;

	assign cur.day   = day_q;
	assign cur.month = month_q;
	assign cur.cent  = cent_q;
	assign cur.yic   = yic_q;

	cdo_step_unit u_step (
		.cur  (cur),
		.back (back_q),
		.res  (sres)
	);

	assign start_bad = (month_q < cdo_pkg::MONTH_JAN) || (month_q > cdo_pkg::MONTH_DEC) ||
		(year_q < cdo_pkg::YEAR_MIN) || (year_q > cdo_pkg::YEAR_MAX) ||
		(day_q == '0) || (day_q > sres.mlen);

	// January and February belong to the previous year
	assign early = (month_q <= cdo_pkg::MONTH_FEB);
	always_comb begin
		z_cent = cent_q;
		z_yic  = yic_q;
		z_mon  = month_q;
		if (early) begin
			z_mon = month_q + 4'd12;
			if (yic_q == '0) begin
				z_cent = cent_q - 7'd1;
				z_yic  = cdo_pkg::YIC_LAST;
			end else begin
				z_yic = yic_q - 7'd1;
			end
		end
	end

	assign z_sum = cdo_pkg::ZSUM_W'(z_yic) + cdo_pkg::ZSUM_W'(z_yic >> 2) +
		cdo_pkg::ZSUM_W'(z_cent >> 2) + cdo_pkg::ZSUM_W'(z_cent) * 10'd5 +
		cdo_pkg::ZSUM_W'(cdo_pkg::zeller_month(z_mon)) + cdo_pkg::ZSUM_W'(day_q) + 10'd6;

	assign quo_prod = cdo_pkg::DIV7_PW'(wsum_q) * cdo_pkg::DIV7_PW'(cdo_pkg::DIV7_MUL);
	assign wrem     = wsum_q - cdo_pkg::ZSUM_W'(wquo_q) * 10'd7;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cdo_pkg::ST_IDLE:  if (in_acc) state_d = cdo_pkg::ST_SPLIT;
			cdo_pkg::ST_SPLIT: state_d = cdo_pkg::ST_REM;
			cdo_pkg::ST_REM:   state_d = cdo_pkg::ST_CHECK;
			cdo_pkg::ST_CHECK: state_d = start_bad ? cdo_pkg::ST_OUT : cdo_pkg::ST_STEP;
			cdo_pkg::ST_STEP:  if (cnt_q == '0 || sres.stop) state_d = cdo_pkg::ST_WSUM;
			cdo_pkg::ST_WSUM:  state_d = cdo_pkg::ST_WDIV;
			cdo_pkg::ST_WDIV:  state_d = cdo_pkg::ST_OUT;
			cdo_pkg::ST_OUT:   if (out_free) state_d = cdo_pkg::ST_IDLE;
			default:           state_d = cdo_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cdo_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			cdo_pkg::ST_IDLE: begin
				day_q   <= din.start_day;
				month_q <= din.start_month;
				year_q  <= din.start_year;
				back_q  <= din.go_back;
				cnt_q   <= cnt_cap;
				stat_q  <= cdo_pkg::STAT_OK;
			end
			cdo_pkg::ST_SPLIT: begin
				cent_q <= cent_prod[cdo_pkg::DIV100_SH +: cdo_pkg::CENT_W];
			end
			cdo_pkg::ST_REM: begin
				yic_q <= cdo_pkg::YIC_W'(year_q - cent_x100);
			end
			cdo_pkg::ST_CHECK: begin
				if (start_bad) stat_q <= cdo_pkg::STAT_INVALID;
			end
			cdo_pkg::ST_STEP: begin
				if (cnt_q != '0) begin
					if (sres.stop) begin
						stat_q <= cdo_pkg::STAT_RANGE;
					end else begin
						day_q   <= sres.next.day;
						month_q <= sres.next.month;
						cent_q  <= sres.next.cent;
						yic_q   <= sres.next.yic;
						cnt_q   <= cnt_q - 16'd1;
					end
				end
			end
			cdo_pkg::ST_WSUM: begin
				wsum_q <= z_sum;
			end
			cdo_pkg::ST_WDIV: begin
				wquo_q <= quo_prod[cdo_pkg::DIV7_SH +: 7];
			end
			cdo_pkg::ST_OUT: begin
			end
			default: begin
			end
		endcase
	end

	// output register; hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (state_q == cdo_pkg::ST_OUT && out_free) begin
			ov_q <= 1'b1;
		end else if (dout.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == cdo_pkg::ST_OUT && out_free) begin
			o_stat_q <= stat_q;
			if (stat_q == cdo_pkg::STAT_INVALID) begin
				o_day_q   <= '0;
				o_month_q <= '0;
				o_year_q  <= '0;
				o_wday_q  <= '0;
				o_leap_q  <= 1'b0;
				o_mlen_q  <= '0;
			end else begin
				o_day_q   <= day_q;
				o_month_q <= month_q;
				o_year_q  <= cent_x100 + cdo_pkg::YEAR_W'(yic_q);
				o_wday_q  <= wrem[cdo_pkg::WDAY_W-1:0];
				o_leap_q  <= sres.leap;
				o_mlen_q  <= sres.mlen;
			end
		end
	end

	assign dout.valid        = ov_q;
	assign dout.end_day      = o_day_q;
	assign dout.end_month    = o_month_q;
	assign dout.end_year     = o_year_q;
	assign dout.weekday      = o_wday_q;
	assign dout.leap_year    = o_leap_q;
	assign dout.month_length = o_mlen_q;
	assign dout.status       = o_stat_q;

endmodule

[rtl/cdo_step_unit.sv]
module cdo_step_unit (
	input  cdo_pkg::date_t     cur,
	input  logic               back,
	output cdo_pkg::step_res_t res
);

	logic                          leap;
	logic [cdo_pkg::DAY_W-1:0]     len_cur;
	logic [cdo_pkg::DAY_W-1:0]     len_prev;
	logic                          at_max;
	logic                          at_min;

	assign leap     = cdo_pkg::is_leap(cur.cent, cur.yic);
	assign len_cur  = cdo_pkg::month_len(cur.month, leap);
	assign len_prev = cdo_pkg::month_len(cur.month - 4'd1, leap);
	assign at_max   = (cur.cent == cdo_pkg::CENT_LAST) && (cur.yic == cdo_pkg::YIC_LAST);
	assign at_min   = (cur.cent == '0) && (cur.yic == 7'd1);

	always_comb begin
		res.next = cur;
		res.stop = 1'b0;
		res.leap = leap;
		res.mlen = len_cur;
		if (!back) begin
			priority if (cur.day != len_cur) begin
				res.next.day = cur.day + 5'd1;
			end else if (cur.month < cdo_pkg::MONTH_DEC) begin
				res.next.month = cur.month + 4'd1;
				res.next.day   = 5'd1;
			end else if (!at_max) begin
				if (cur.yic == cdo_pkg::YIC_LAST) begin
					res.next.yic  = '0;
					res.next.cent = cur.cent + 7'd1;
				end else begin
					res.next.yic = cur.yic + 7'd1;
				end
				res.next.month = cdo_pkg::MONTH_JAN;
				res.next.day   = 5'd1;
			end else begin
				res.stop = 1'b1;
			end
		end else begin
			priority if (cur.day != 5'd1) begin
				res.next.day = cur.day - 5'd1;
			end else if (cur.month > cdo_pkg::MONTH_JAN) begin
				res.next.month = cur.month - 4'd1;
				res.next.day   = len_prev;
			end else if (!at_min) begin
				if (cur.yic == '0) begin
					res.next.yic  = cdo_pkg::YIC_LAST;
					res.next.cent = cur.cent - 7'd1;
				end else begin
					res.next.yic = cur.yic - 7'd1;
				end
				res.next.month = cdo_pkg::MONTH_DEC;
				res.next.day   = 5'd31;
			end else begin
				res.stop = 1'b1;
			end
		end
	end

endmodule
